### sv/utf8_text_detector_core_macros.svh
// Assertion helpers shared by the RTL of the UTF-8 text detector.
`ifndef UTF8_TEXT_DETECTOR_CORE_MACROS_SVH
`define UTF8_TEXT_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define UTD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define UTD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/utf8td_pkg.sv
package utf8td_pkg;

    // A sequence cut short at the end is accepted only while shorter than this, in bytes.
    localparam int MAX_CHAR_BYTES = 4;

    // Width of the continuation and distance counters.
    localparam int CNT_W = 3;

    localparam logic [7:0] TOP_BIT_MASK = 8'h80;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_CODE    = 8'h80;

    // Classification of one byte.
    typedef struct packed {
        logic             ascii;    // top bit clear
        logic             is_cont;  // 10xxxxxx
        logic [CNT_W-1:0] owed;     // continuations a lead byte asks for
    } utf8td_dec_t;

endpackage

### sv/utf8td_decode.sv
module utf8td_decode (
    input  logic [7:0]               data_byte,
    output utf8td_pkg::utf8td_dec_t  dec
);
    import utf8td_pkg::*;

    // Leading-ones priority encode; the count minus one is the number owed, and an ASCII byte owes none.
    always_comb begin
        dec.ascii   = (data_byte & TOP_BIT_MASK) == 8'h00;
        dec.is_cont = (data_byte & CONT_MASK) == CONT_CODE;
        unique casez (data_byte)
            8'b0???????: dec.owed = CNT_W'(0);
            8'b10??????: dec.owed = CNT_W'(0);
            8'b110?????: dec.owed = CNT_W'(1);
            8'b1110????: dec.owed = CNT_W'(2);
            8'b11110???: dec.owed = CNT_W'(3);
            8'b111110??: dec.owed = CNT_W'(4);
            8'b1111110?: dec.owed = CNT_W'(5);
            8'b11111110: dec.owed = CNT_W'(6);
            8'b11111111: dec.owed = CNT_W'(7);
            default:     dec.owed = CNT_W'(0);
        endcase
    end

endmodule

### sv/utf8td_track.sv
`include "utf8_text_detector_core_macros.svh"

module utf8td_track (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,
    input  logic                     last_byte,
    input  utf8td_pkg::utf8td_dec_t  dec,
    output logic                     is_utf8,
    output logic                     all_ascii
);
    import utf8td_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHAR_BYTES);

    logic [CNT_W-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0] dist_reg, dist_next;
    logic             ascii_reg, ascii_next;
    logic             failed_reg, failed_next;

    // State update for the byte leaving the input register.
    always_comb begin
        pend_next   = pend_reg;
        dist_next   = dist_reg;
        failed_next = failed_reg;
        ascii_next  = ascii_reg & dec.ascii;
        if (!failed_reg) begin
            if (pend_reg != '0) begin
                if (!dec.is_cont) begin
                    failed_next = 1'b1;
                end else begin
                    pend_next = pend_reg - CNT_W'(1);
                end
                if (dist_reg < MAX_CNT) begin
                    dist_next = dist_reg + CNT_W'(1);
                end
            end else begin
                dist_next = CNT_W'(1);
                if (!dec.ascii) begin
                    if (dec.is_cont) begin
                        failed_next = 1'b1;
                    end else begin
                        pend_next = dec.owed;
                    end
                end
            end
        end
    end

    // Verdict, taken from the state after this byte.
    assign all_ascii = ascii_next;
    assign is_utf8   = !failed_next && !ascii_next &&
                       ((pend_next == '0) || (dist_next < MAX_CNT));

    // The final byte of a buffer returns the state to its reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= '0;
            dist_reg   <= '0;
            ascii_reg  <= 1'b1;
            failed_reg <= 1'b0;
        end else if (step) begin
            if (last_byte) begin
                pend_reg   <= '0;
                dist_reg   <= '0;
                ascii_reg  <= 1'b1;
                failed_reg <= 1'b0;
            end else begin
                pend_reg   <= pend_next;
                dist_reg   <= dist_next;
                ascii_reg  <= ascii_next;
                failed_reg <= failed_next;
            end
        end
    end

    `UTD_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, step && last_byte, pend_reg == '0 && dist_reg == '0 && ascii_reg && !failed_reg, "state not cleared after final byte")
    `UTD_ASSERT_NEXT(a_failed_sticks, aclk, aresetn, failed_reg && !(step && last_byte), failed_reg, "failure dropped inside a buffer")
    `UTD_ASSERT_NOW(a_dist_saturates, aclk, aresetn, 1'b1, dist_reg <= MAX_CNT, "start distance beyond saturation")
    `UTD_ASSERT_NOW(a_pend_not_ascii, aclk, aresetn, pend_reg != '0, !ascii_reg, "continuations owed in an ASCII buffer")

endmodule

### sv/utf8_text_detector_core.sv
// UTF-8 text detector core.
// Input channel (s_valid/s_ready): one byte of a buffer per transaction in
// s_data_byte, with s_last_byte high on the buffer's final byte.
// Result channel (m_valid/m_ready): one transaction per buffer, issued after
// its final byte; m_is_utf8 is high when the buffer is valid UTF-8 text that
// is not pure ASCII, and m_all_ascii when no byte had its top bit set.
// Throughput is one byte per cycle unless a final byte waits on a stalled
// receiver. A byte is held in an input register, classified by a leading-ones
// encoder and folded into the buffer state as it leaves that register; the
// verdict of a final byte is held in the output register, which drives the
// result channel.
// When the receiver stalls, the verdict waits in the output register; bytes
// that are not final keep flowing, and a final byte waits in the input
// register until the output register is free.
// Reset (aresetn low, synchronous) empties both registers and returns the
// buffer state to the start of a new buffer.
`include "utf8_text_detector_core_macros.svh"

module utf8_text_detector_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_utf8,
    output logic       m_all_ascii
);
    import utf8td_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        m_valid_reg;
    logic        m_is_utf8_reg;
    logic        m_all_ascii_reg;
    logic        out_free;
    logic        advance;
    logic        verdict_utf8;
    logic        verdict_ascii;
    utf8td_dec_t dec;

    // A byte leaves the input register unless it is final and the result slot is taken.
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    utf8td_decode u_decode (
        .data_byte (in_byte_reg),
        .dec       (dec)
    );

    utf8td_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .last_byte (in_last_reg),
        .dec       (dec),
        .is_utf8   (verdict_utf8),
        .all_ascii (verdict_ascii)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_is_utf8_reg   <= verdict_utf8;
            m_all_ascii_reg <= verdict_ascii;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_is_utf8   = m_is_utf8_reg;
    assign m_all_ascii = m_all_ascii_reg;

    `UTD_ASSERT_NOW(a_verdict_exclusive, aclk, aresetn, m_valid_reg, !(m_is_utf8_reg && m_all_ascii_reg), "verdict both UTF-8 and ASCII")
    `UTD_ASSERT_NOW(a_stall_means_full, aclk, aresetn, !s_ready, in_valid_reg && in_last_reg && m_valid_reg && !m_ready, "input stalled without cause")
    `UTD_ASSERT_NEXT(a_final_gives_result, aclk, aresetn, advance && in_last_reg, m_valid_reg, "final byte produced no result")

endmodule

### verif/utf8_text_detector_core_tb.sv
module utf8_text_detector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8td_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_BYTES   = 400;
    localparam int TAIL_BYTES     = 60;
    localparam int LONG_HOLD      = 250;
    localparam int HOLD_AFTER     = 20;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } text_byte_t;

    typedef struct {
        logic is_utf8;
        logic all_ascii;
    } verdict_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_last_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_is_utf8;
    logic       m_all_ascii;

    // Bytes waiting to be offered and verdicts waiting to arrive.
    text_byte_t pending_bytes[$];
    verdict_t   expected_verdicts[$];
    logic [7:0] scratch[$];

    // Predicted buffer state.
    logic [CNT_W-1:0] cont_owed = '0;
    logic             no_high_bit = 1'b1;
    logic             rejected = 1'b0;
    logic [CNT_W-1:0] span = '0;

    int error_count = 0;
    int verdicts_seen = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    utf8_text_detector_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_utf8   (m_is_utf8),
        .m_all_ascii (m_all_ascii)
    );

    always #4 aclk = ~aclk;

    function automatic int count_leading_ones(input logic [7:0] b);
        int n;
        n = 0;
        while (n < 8 && b[7-n])
            n++;
        return n;
    endfunction

    // Fold one accepted byte into the predicted state; a final byte yields a verdict.
    function automatic void absorb_byte(input logic [7:0] b, input logic fin);
        int ones;
        verdict_t v;
        if ((b & TOP_BIT_MASK) != 8'h00)
            no_high_bit = 1'b0;
        if (!rejected) begin
            if (cont_owed != '0) begin
                if ((b & CONT_MASK) != CONT_CODE)
                    rejected = 1'b1;
                else
                    cont_owed = cont_owed - 1'b1;
                if (span < MAX_CHAR_BYTES)
                    span = span + 1'b1;
            end else begin
                span = CNT_W'(1);
                if ((b & TOP_BIT_MASK) != 8'h00) begin
                    ones = count_leading_ones(b);
                    if (ones <= 1)
                        rejected = 1'b1;
                    else
                        cont_owed = CNT_W'(ones - 1);
                end
            end
        end
        if (fin) begin
            v.is_utf8 = !rejected && !no_high_bit &&
                        (cont_owed == '0 || span < MAX_CHAR_BYTES);
            v.all_ascii = no_high_bit;
            expected_verdicts.push_back(v);
            cont_owed = '0;
            no_high_bit = 1'b1;
            rejected = 1'b0;
            span = '0;
        end
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic fin);
        text_byte_t t;
        t.data = b;
        t.last = fin;
        pending_bytes.push_back(t);
    endtask

    // One buffer: mostly well-formed characters, some corrupted, some pure noise.
    task automatic queue_random_buffer();
        int mode;
        int chars;
        int c;
        int k;
        int seq_len;
        int keep;
        int pos;
        logic [7:0] lead;
        scratch.delete();
        mode = $urandom_range(0, 9);
        if (mode >= 8) begin
            repeat ($urandom_range(1, 6))
                scratch.push_back(8'($urandom_range(0, 255)));
        end else begin
            chars = $urandom_range(1, 5);
            for (c = 0; c < chars; c++) begin
                k = $urandom_range(0, 9);
                if (k < 3)
                    seq_len = 1;
                else if (k < 9)
                    seq_len = $urandom_range(2, 4);
                else
                    seq_len = $urandom_range(5, 8);
                if (seq_len == 1) begin
                    scratch.push_back(8'($urandom_range(0, 127)));
                end else begin
                    lead = (8'hFF << (8 - seq_len)) | (8'($urandom) & (8'hFF >> (seq_len + 1)));
                    keep = seq_len;
                    // Occasionally cut the final character short.
                    if (c == chars - 1 && $urandom_range(0, 3) == 0)
                        keep = $urandom_range(1, seq_len - 1);
                    scratch.push_back(lead);
                    for (pos = 1; pos < keep; pos++)
                        scratch.push_back(8'h80 | 8'($urandom_range(0, 63)));
                end
            end
            if (mode == 7)
                scratch[$urandom_range(0, scratch.size() - 1)] = 8'($urandom_range(0, 255));
        end
        for (pos = 0; pos < scratch.size(); pos++)
            add_byte(scratch[pos], pos == scratch.size() - 1);
    endtask

    // Sender: offers queued bytes with random idle bursts, none near the end.
    always @(posedge aclk) begin : byte_driver
        logic offering;
        text_byte_t t;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data_byte <= 8'h00;
            s_last_byte <= 1'b0;
            send_gap = 0;
        end else begin
            offering = s_valid;
            if (s_valid && s_ready) begin
                absorb_byte(s_data_byte, s_last_byte);
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bytes.size() > 0) begin
                    if (pending_bytes.size() > TAIL_BYTES && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(0, 18);
                    end else begin
                        t = pending_bytes.pop_front();
                        s_data_byte <= t.data;
                        s_last_byte <= t.last;
                        offering = 1'b1;
                    end
                end
            end
            s_valid <= offering;
        end
    end

    // Receiver: checks each verdict transaction and stalls at random.
    always @(posedge aclk) begin : verdict_monitor
        logic ready_next;
        verdict_t v;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                verdicts_seen++;
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected verdict, expected none, got is_utf8=%0b all_ascii=%0b",
                             $time, m_is_utf8, m_all_ascii);
                    error_count++;
                end else begin
                    v = expected_verdicts.pop_front();
                    if (m_is_utf8 !== v.is_utf8) begin
                        $display("%0t: is_utf8 mismatch, expected %0b, got %0b",
                                 $time, v.is_utf8, m_is_utf8);
                        error_count++;
                    end
                    if (m_all_ascii !== v.all_ascii) begin
                        $display("%0t: all_ascii mismatch, expected %0b, got %0b",
                                 $time, v.all_ascii, m_all_ascii);
                        error_count++;
                    end
                end
            end
            // One long hold lets the block fill up and stall the sender.
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (!hold_done &&
                         (verdicts_seen >= HOLD_AFTER || pending_bytes.size() <= TAIL_BYTES)) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                ready_next = 1'b0;
            end else if (pending_bytes.size() <= TAIL_BYTES) begin
                ready_next = 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                ready_next = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 18);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_ready <= ready_next;
        end
    end

    // Watchdog: too many cycles without any transaction ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout with %0d verdicts outstanding",
                         $time, expected_verdicts.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        // Single-byte buffers: ASCII extremes, lone leads, lone continuation.
        add_byte(8'h00, 1'b1);
        add_byte(8'h7F, 1'b1);
        add_byte(8'hC3, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFE, 1'b1);
        add_byte(8'h80, 1'b1);
        // Complete two, three and four byte characters.
        add_byte(8'hC3, 1'b0);
        add_byte(8'hA9, 1'b1);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hAC, 1'b1);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h9F, 1'b0);
        add_byte(8'h98, 1'b0);
        add_byte(8'hBF, 1'b1);
        // A five byte lead cut short after four bytes is rejected.
        add_byte(8'hF8, 1'b0);
        add_byte(8'h88, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b1);
        // Missing continuation.
        add_byte(8'hC3, 1'b0);
        add_byte(8'h41, 1'b1);
        // A leading continuation fails the buffer; the bytes after it do not undo the failure.
        add_byte(8'h80, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hC3, 1'b1);
        while (pending_bytes.size() < 24 + RANDOM_BYTES)
            queue_random_buffer();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(posedge aclk);
        while (pending_bytes.size() > 0 || s_valid || expected_verdicts.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
